// ===== design/esc_pkg.sv =====
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types, constants and the month-length lookup for the epoch seconds
// to calendar converter.
// ----------------------------------------------------------------------------
package esc_pkg;

    // field widths
    localparam int SEC_W   = 31;
    localparam int DAYS_W  = 15;
    localparam int QUAD_W  = 5;
    localparam int CNT_W   = 4;
    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DOM_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;

    // calendar constants
    localparam int BASE_YEAR      = 2016;
    localparam int SECS_PER_DAY   = 86400;
    localparam int SECS_PER_HOUR  = 3600;
    localparam int SECS_PER_MIN   = 60;
    localparam int DAYS_PER_QUAD  = 1461;
    localparam int DAYS_LEAP_YEAR = 366;
    localparam int DAYS_COMMON    = 365;
    localparam int FEB_LEAP_DAYS  = 29;
    localparam int LAST_MONTH     = 12;

    // quotient bits per division pass, top bit index
    localparam int DAYS_TOP = 14;
    localparam int HOUR_TOP = 4;
    localparam int MIN_TOP  = 5;
    localparam int QUAD_TOP = 4;

    // divisors pre-shifted to the top quotient bit of each pass
    localparam logic [SEC_W-1:0] DAY_DIV_INIT  = SEC_W'(SECS_PER_DAY * (2 ** DAYS_TOP));
    localparam logic [SEC_W-1:0] HOUR_DIV_INIT = SEC_W'(SECS_PER_HOUR * (2 ** HOUR_TOP));
    localparam logic [SEC_W-1:0] MIN_DIV_INIT  = SEC_W'(SECS_PER_MIN * (2 ** MIN_TOP));
    localparam logic [SEC_W-1:0] QUAD_DIV_INIT = SEC_W'(DAYS_PER_QUAD * (2 ** QUAD_TOP));

    // result of the shared compare and subtract unit
    typedef struct packed {
        logic             ge;
        logic [SEC_W-1:0] diff;
    } t_sub_res;

    // days in a month, february follows the leap flag
    function automatic logic [DOM_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
        logic [DOM_W-1:0] len;
        case (month)
            4'd1:    len = DOM_W'(31);
            4'd2:    len = leap ? DOM_W'(FEB_LEAP_DAYS) : DOM_W'(28);
            4'd3:    len = DOM_W'(31);
            4'd4:    len = DOM_W'(30);
            4'd5:    len = DOM_W'(31);
            4'd6:    len = DOM_W'(30);
            4'd7:    len = DOM_W'(31);
            4'd8:    len = DOM_W'(31);
            4'd9:    len = DOM_W'(30);
            4'd10:   len = DOM_W'(31);
            4'd11:   len = DOM_W'(30);
            4'd12:   len = DOM_W'(31);
            default: len = DOM_W'(0);
        endcase
        return len;
    endfunction

endpackage

// ===== design/epoch_seconds_to_calendar_top.sv =====
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_top
// Converts seconds since 2016-01-01 00:00:00 into year, month, day, hour,
// minute and second using one shared compare and subtract unit.
// ----------------------------------------------------------------------------
//  channel   | ports                                   | handshake
//  ----------+-----------------------------------------+----------------------
//  request   | i_epoch_seconds                         | start high, busy low
//  result    | o_year o_month o_day_of_month o_hour    | o_valid, one cycle
//            | o_minute o_second                       |
//
//  A request runs one compare and subtract step a cycle until o_valid: 15
//  steps for days, 5 for hours, 6 for minutes, 5 for four-year groups, 1 to
//  3 for years and 1 to 12 for months, in that order.
//  busy is high while the sequencer runs; the result strobe cannot be
//  stalled and a new request may be accepted in the strobe cycle.
//  Reset (synchronous, active low) returns the sequencer to idle.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [esc_pkg::SEC_W-1:0]   i_epoch_seconds,
    output logic                        o_valid,
    output logic [esc_pkg::YEAR_W-1:0]  o_year,
    output logic [esc_pkg::MONTH_W-1:0] o_month,
    output logic [esc_pkg::DOM_W-1:0]   o_day_of_month,
    output logic [esc_pkg::HOUR_W-1:0]  o_hour,
    output logic [esc_pkg::MIN_W-1:0]   o_minute,
    output logic [esc_pkg::MIN_W-1:0]   o_second
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DAYS   = 3'd1;
    localparam logic [2:0] S_HOUR   = 3'd2;
    localparam logic [2:0] S_MINUTE = 3'd3;
    localparam logic [2:0] S_QUAD   = 3'd4;
    localparam logic [2:0] S_LEAP   = 3'd5;
    localparam logic [2:0] S_COMMON = 3'd6;
    localparam logic [2:0] S_MONTH  = 3'd7;

    logic [2:0]                        r_state;
    logic [esc_pkg::SEC_W-1:0]         r_rem;
    logic [esc_pkg::SEC_W-1:0]         r_div;
    logic [esc_pkg::DAYS_W-1:0]        r_quot;
    logic [esc_pkg::DAYS_W-1:0]        r_days;
    logic [esc_pkg::CNT_W-1:0]         r_cnt;
    logic [esc_pkg::QUAD_W-1:0]        r_quads;
    logic [1:0]                        r_yadd;
    logic                              r_leap;
    logic [esc_pkg::MONTH_W-1:0]       r_month;
    logic [esc_pkg::HOUR_W-1:0]        r_hour;
    logic [esc_pkg::MIN_W-1:0]         r_minute;
    logic [esc_pkg::MIN_W-1:0]         r_second;
    logic                              r_valid;

    logic [esc_pkg::SEC_W-1:0]         n_rem;
    logic [esc_pkg::DAYS_W-1:0]        n_quot;
    logic [esc_pkg::MONTH_W-1:0]       n_month;
    logic                              w_finish;
    esc_pkg::t_sub_res                 w_res;

    // shared compare and subtract step
    esc_sub_unit u_sub (
        .i_a   (r_rem),
        .i_b   (r_div),
        .o_res (w_res)
    );

    assign n_rem    = w_res.ge ? w_res.diff : r_rem;
    assign n_quot   = {r_quot[esc_pkg::DAYS_W-2:0], w_res.ge};
    assign n_month  = r_month + 1'b1;
    assign w_finish = (r_state == S_MONTH) &&
                      (!w_res.ge || r_month == esc_pkg::MONTH_W'(esc_pkg::LAST_MONTH));
    assign busy     = (r_state != S_IDLE);

    // sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_finish;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_DAYS;
                    end
                end
                S_DAYS: begin
                    if (r_cnt == '0) begin
                        r_state <= S_HOUR;
                    end
                end
                S_HOUR: begin
                    if (r_cnt == '0) begin
                        r_state <= S_MINUTE;
                    end
                end
                S_MINUTE: begin
                    if (r_cnt == '0) begin
                        r_state <= S_QUAD;
                    end
                end
                S_QUAD: begin
                    if (r_cnt == '0) begin
                        r_state <= S_LEAP;
                    end
                end
                S_LEAP: begin
                    r_state <= w_res.ge ? S_COMMON : S_MONTH;
                end
                S_COMMON: begin
                    if (r_cnt == '0 || !w_res.ge) begin
                        r_state <= S_MONTH;
                    end
                end
                S_MONTH: begin
                    if (w_finish) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_rem <= i_epoch_seconds;
                r_div <= esc_pkg::DAY_DIV_INIT;
                r_cnt <= esc_pkg::CNT_W'(esc_pkg::DAYS_TOP);
            end
            S_DAYS: begin
                r_rem  <= n_rem;
                r_quot <= n_quot;
                if (r_cnt == '0) begin
                    r_days <= n_quot;
                    r_div  <= esc_pkg::HOUR_DIV_INIT;
                    r_cnt  <= esc_pkg::CNT_W'(esc_pkg::HOUR_TOP);
                end else begin
                    r_div <= r_div >> 1;
                    r_cnt <= r_cnt - 1'b1;
                end
            end
            S_HOUR: begin
                r_rem  <= n_rem;
                r_quot <= n_quot;
                if (r_cnt == '0) begin
                    r_hour <= n_quot[esc_pkg::HOUR_W-1:0];
                    r_div  <= esc_pkg::MIN_DIV_INIT;
                    r_cnt  <= esc_pkg::CNT_W'(esc_pkg::MIN_TOP);
                end else begin
                    r_div <= r_div >> 1;
                    r_cnt <= r_cnt - 1'b1;
                end
            end
            S_MINUTE: begin
                r_quot <= n_quot;
                if (r_cnt == '0) begin
                    r_minute <= n_quot[esc_pkg::MIN_W-1:0];
                    r_second <= n_rem[esc_pkg::MIN_W-1:0];
                    r_rem    <= esc_pkg::SEC_W'(r_days);
                    r_div    <= esc_pkg::QUAD_DIV_INIT;
                    r_cnt    <= esc_pkg::CNT_W'(esc_pkg::QUAD_TOP);
                end else begin
                    r_rem <= n_rem;
                    r_div <= r_div >> 1;
                    r_cnt <= r_cnt - 1'b1;
                end
            end
            S_QUAD: begin
                r_rem  <= n_rem;
                r_quot <= n_quot;
                if (r_cnt == '0) begin
                    r_quads <= n_quot[esc_pkg::QUAD_W-1:0];
                    r_yadd  <= 2'd0;
                    r_div   <= esc_pkg::SEC_W'(esc_pkg::DAYS_LEAP_YEAR);
                end else begin
                    r_div <= r_div >> 1;
                    r_cnt <= r_cnt - 1'b1;
                end
            end
            S_LEAP: begin
                // leap year leads each group
                r_rem   <= n_rem;
                r_month <= esc_pkg::MONTH_W'(1);
                r_cnt   <= esc_pkg::CNT_W'(1);
                if (w_res.ge) begin
                    r_leap <= 1'b0;
                    r_yadd <= r_yadd + 1'b1;
                    r_div  <= esc_pkg::SEC_W'(esc_pkg::DAYS_COMMON);
                end else begin
                    r_leap <= 1'b1;
                    r_div  <= esc_pkg::SEC_W'(esc_pkg::month_len(esc_pkg::MONTH_W'(1),
                                                                 1'b1));
                end
            end
            S_COMMON: begin
                r_rem <= n_rem;
                r_cnt <= r_cnt - 1'b1;
                if (w_res.ge) begin
                    r_yadd <= r_yadd + 1'b1;
                end
                if (r_cnt == '0 || !w_res.ge) begin
                    r_div <= esc_pkg::SEC_W'(esc_pkg::month_len(esc_pkg::MONTH_W'(1),
                                                                r_leap));
                end
            end
            S_MONTH: begin
                // walk the month table until the day fits
                if (!w_finish) begin
                    r_rem   <= w_res.diff;
                    r_month <= n_month;
                    r_div   <= esc_pkg::SEC_W'(esc_pkg::month_len(n_month, r_leap));
                end
            end
            default: begin
                r_rem <= r_rem;
            end
        endcase
    end

    // result registers, loaded on the last month step
    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            o_year         <= esc_pkg::YEAR_W'(esc_pkg::BASE_YEAR)
                              + esc_pkg::YEAR_W'({r_quads, 2'b00})
                              + esc_pkg::YEAR_W'(r_yadd);
            o_month        <= r_month;
            o_day_of_month <= r_rem[esc_pkg::DOM_W-1:0] + 1'b1;
            o_hour         <= r_hour;
            o_minute       <= r_minute;
            o_second       <= r_second;
        end
    end

    assign o_valid = r_valid;

endmodule

// ===== design/esc_sub_unit.sv =====
// ----------------------------------------------------------------------------
// esc_sub_unit
// Shared compare and subtract unit: flags a >= b and gives a - b.
// ----------------------------------------------------------------------------
module esc_sub_unit (
    input  logic [esc_pkg::SEC_W-1:0] i_a,
    input  logic [esc_pkg::SEC_W-1:0] i_b,
    output esc_pkg::t_sub_res         o_res
);

    logic [esc_pkg::SEC_W:0] w_wide;

    // one extra bit carries the borrow
    assign w_wide     = {1'b0, i_a} - {1'b0, i_b};
    assign o_res.ge   = ~w_wide[esc_pkg::SEC_W];
    assign o_res.diff = w_wide[esc_pkg::SEC_W-1:0];

endmodule

// ===== tb/sv/tb_epoch_seconds_to_calendar_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_epoch_seconds_to_calendar_top
// Self-checking bench for the epoch seconds to calendar converter. A table of
// directed requests covers the day, month, year and four-year group edges
// and the ends of the input range. Random requests follow: fully random
// counts, calendar edges with random times of day, and counts near the top
// of the range. Each request is accepted on start high with busy low. Each
// o_valid strobe is compared field by field with the oldest predicted date.
// ----------------------------------------------------------------------------
module tb_epoch_seconds_to_calendar_top;

    localparam int N_RANDOM    = 1400;
    localparam int DRAIN_WAIT  = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [esc_pkg::SEC_W-1:0] SEC_MAX = {esc_pkg::SEC_W{1'b1}};

    // month lengths for a common year, index 1 = january
    localparam int MONTH_DAYS [0:12] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef struct packed {
        logic [esc_pkg::YEAR_W-1:0]  year;
        logic [esc_pkg::MONTH_W-1:0] month;
        logic [esc_pkg::DOM_W-1:0]   dom;
        logic [esc_pkg::HOUR_W-1:0]  hour;
        logic [esc_pkg::MIN_W-1:0]   minute;
        logic [esc_pkg::MIN_W-1:0]   second;
    } t_cal_date;

    typedef struct packed {
        logic [esc_pkg::SEC_W-1:0] secs;
        logic                      typed;
        t_cal_date                 date;
    } t_dir_row;

    localparam t_cal_date NO_DATE = '0;
    localparam int N_DIRECTED = 25;

    // directed requests, dates typed in only where they are obvious
    localparam t_dir_row DIR_ROWS [0:N_DIRECTED-1] = '{
        '{31'd0,          1'b1, '{12'd2016, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0}},
        '{31'd59,         1'b1, '{12'd2016, 4'd1,  5'd1,  5'd0,  6'd0,  6'd59}},
        '{31'd60,         1'b1, '{12'd2016, 4'd1,  5'd1,  5'd0,  6'd1,  6'd0}},
        '{31'd3599,       1'b1, '{12'd2016, 4'd1,  5'd1,  5'd0,  6'd59, 6'd59}},
        '{31'd3600,       1'b1, '{12'd2016, 4'd1,  5'd1,  5'd1,  6'd0,  6'd0}},
        '{31'd86399,      1'b1, '{12'd2016, 4'd1,  5'd1,  5'd23, 6'd59, 6'd59}},
        '{31'd86400,      1'b1, '{12'd2016, 4'd1,  5'd2,  5'd0,  6'd0,  6'd0}},
        '{31'd2678400,    1'b1, '{12'd2016, 4'd2,  5'd1,  5'd0,  6'd0,  6'd0}},
        '{31'd5097600,    1'b1, '{12'd2016, 4'd2,  5'd29, 5'd0,  6'd0,  6'd0}},
        '{31'd5184000,    1'b1, '{12'd2016, 4'd3,  5'd1,  5'd0,  6'd0,  6'd0}},
        '{31'd31535999,   1'b0, NO_DATE},
        '{31'd31622399,   1'b1, '{12'd2016, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59}},
        '{31'd31622400,   1'b1, '{12'd2017, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0}},
        '{31'd36633600,   1'b0, NO_DATE},
        '{31'd36720000,   1'b0, NO_DATE},
        '{31'd94694400,   1'b0, NO_DATE},
        '{31'd126230399,  1'b0, NO_DATE},
        '{31'd126230400,  1'b1, '{12'd2020, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0}},
        '{31'd131328000,  1'b0, NO_DATE},
        '{31'd2147483647, 1'b1, '{12'd2084, 4'd1,  5'd19, 5'd3,  6'd14, 6'd7}},
        '{31'd2147483646, 1'b0, NO_DATE},
        '{31'h55555555,   1'b0, NO_DATE},
        '{31'h2AAAAAAA,   1'b0, NO_DATE},
        '{31'd2145916800, 1'b0, NO_DATE},
        '{31'd2145916799, 1'b0, NO_DATE}
    };

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic [esc_pkg::SEC_W-1:0]   i_epoch_seconds;
    logic                        o_valid;
    logic [esc_pkg::YEAR_W-1:0]  o_year;
    logic [esc_pkg::MONTH_W-1:0] o_month;
    logic [esc_pkg::DOM_W-1:0]   o_day_of_month;
    logic [esc_pkg::HOUR_W-1:0]  o_hour;
    logic [esc_pkg::MIN_W-1:0]   o_minute;
    logic [esc_pkg::MIN_W-1:0]   o_second;

    t_cal_date dates_pending [$];
    t_cal_date next_date;
    int        n_errors    = 0;
    int        n_accepted  = 0;
    int        n_checked   = 0;
    int        cycle_count = 0;

    epoch_seconds_to_calendar_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_epoch_seconds (i_epoch_seconds),
        .o_valid         (o_valid),
        .o_year          (o_year),
        .o_month         (o_month),
        .o_day_of_month  (o_day_of_month),
        .o_hour          (o_hour),
        .o_minute        (o_minute),
        .o_second        (o_second)
    );

    // 10 ns clock
    always #5 i_clk = ~i_clk;

    // days in a month, february at 29 in a leap year
    function automatic int unsigned days_in_month(input int unsigned mon, input bit leap);
        if (leap && mon == 2) begin
            return esc_pkg::FEB_LEAP_DAYS;
        end
        return MONTH_DAYS[mon];
    endfunction

    // calendar date of a second count
    function automatic t_cal_date predict_calendar(input logic [esc_pkg::SEC_W-1:0] secs);
        int unsigned days, tod, quads, rem, yr, mon, dim;
        bit          leap;
        t_cal_date   d;
        days  = int'(secs) / esc_pkg::SECS_PER_DAY;
        tod   = int'(secs) % esc_pkg::SECS_PER_DAY;
        quads = days / esc_pkg::DAYS_PER_QUAD;
        rem   = days - quads * esc_pkg::DAYS_PER_QUAD;
        yr    = esc_pkg::BASE_YEAR + 4 * quads;
        leap  = 1'b1;
        // leap year leads each four-year group
        if (rem >= esc_pkg::DAYS_LEAP_YEAR) begin
            leap = 1'b0;
            yr++;
            rem -= esc_pkg::DAYS_LEAP_YEAR;
            while (rem >= esc_pkg::DAYS_COMMON) begin
                yr++;
                rem -= esc_pkg::DAYS_COMMON;
            end
        end
        // walk the months
        mon = 1;
        while (mon < esc_pkg::LAST_MONTH) begin
            dim = days_in_month(mon, leap);
            if (rem < dim) begin
                break;
            end
            rem -= dim;
            mon++;
        end
        d.year   = esc_pkg::YEAR_W'(yr);
        d.month  = esc_pkg::MONTH_W'(mon);
        d.dom    = esc_pkg::DOM_W'(rem + 1);
        d.hour   = esc_pkg::HOUR_W'(tod / esc_pkg::SECS_PER_HOUR);
        d.minute = esc_pkg::MIN_W'((tod % esc_pkg::SECS_PER_HOUR) / esc_pkg::SECS_PER_MIN);
        d.second = esc_pkg::MIN_W'(tod % esc_pkg::SECS_PER_MIN);
        return d;
    endfunction

    // second count at a month edge with a random or extreme time of day
    function automatic logic [esc_pkg::SEC_W-1:0] calendar_edge_secs();
        int unsigned quad, yi, mon, days, tod, m;
        bit          leap;
        quad = $urandom_range(0, 16);
        yi   = $urandom_range(0, 3);
        mon  = $urandom_range(1, esc_pkg::LAST_MONTH);
        leap = (yi == 0);
        days = quad * esc_pkg::DAYS_PER_QUAD;
        if (yi != 0) begin
            days += esc_pkg::DAYS_LEAP_YEAR + esc_pkg::DAYS_COMMON * (yi - 1);
        end
        for (m = 1; m < mon; m++) begin
            days += days_in_month(m, leap);
        end
        if ($urandom_range(0, 1) == 1) begin
            days += days_in_month(mon, leap) - 1;
        end
        case ($urandom_range(0, 2))
            0:       tod = 0;
            1:       tod = esc_pkg::SECS_PER_DAY - 1;
            default: tod = $urandom_range(0, esc_pkg::SECS_PER_DAY - 1);
        endcase
        return esc_pkg::SEC_W'(days * esc_pkg::SECS_PER_DAY + tod);
    endfunction

    // one field against its expectation
    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: mismatch on %s, expected %0d, actual %0d", $time, name, exp_v, act_v);
            n_errors++;
        end
    endtask

    // drive one request after a random gap, return at the falling edge after it is taken
    task automatic send_request(input logic [esc_pkg::SEC_W-1:0] secs, input t_cal_date date);
        int gap;
        gap = $urandom_range(0, 5);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start           <= 1'b1;
        i_epoch_seconds <= secs;
        next_date       <= date;
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
        @(negedge i_clk);
    endtask

    // result check and request capture
    always @(posedge i_clk) begin
        t_cal_date exp_d;
        if (i_rst_n) begin
            if (o_valid === 1'b1) begin
                if (dates_pending.size() == 0) begin
                    $display("%0t: result with no request waiting, actual %0d-%0d-%0d %0d:%0d:%0d",
                             $time, o_year, o_month, o_day_of_month, o_hour, o_minute, o_second);
                    n_errors++;
                end else begin
                    exp_d = dates_pending.pop_front();
                    check_field("year",   int'(exp_d.year),   int'(o_year));
                    check_field("month",  int'(exp_d.month),  int'(o_month));
                    check_field("day",    int'(exp_d.dom),    int'(o_day_of_month));
                    check_field("hour",   int'(exp_d.hour),   int'(o_hour));
                    check_field("minute", int'(exp_d.minute), int'(o_minute));
                    check_field("second", int'(exp_d.second), int'(o_second));
                    n_checked++;
                end
            end
            if (start === 1'b1 && busy === 1'b0) begin
                dates_pending.push_back(next_date);
                n_accepted++;
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    // stimulus
    initial begin
        logic [esc_pkg::SEC_W-1:0] secs;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_epoch_seconds = '0;
        next_date       = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table
        for (int i = 0; i < N_DIRECTED; i++) begin
            send_request(DIR_ROWS[i].secs,
                         DIR_ROWS[i].typed ? DIR_ROWS[i].date
                                           : predict_calendar(DIR_ROWS[i].secs));
        end

        // random mix of full range, calendar edges and the top of the range
        for (int i = 0; i < N_RANDOM; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: secs = esc_pkg::SEC_W'($urandom);
                5, 6, 7, 8:    secs = calendar_edge_secs();
                default:       secs = SEC_MAX - esc_pkg::SEC_W'(
                                   $urandom_range(0, 40 * esc_pkg::SECS_PER_DAY));
            endcase
            send_request(secs, predict_calendar(secs));
        end
        start <= 1'b0;

        // drain
        while (dates_pending.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("%0d directed and %0d random requests, %0d accepted, %0d dates checked",
                 N_DIRECTED, N_RANDOM, n_accepted, n_checked);
        $display("covered day, month, leap and group edges and the full 31-bit range");
        if (n_errors == 0 && dates_pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
